>>> rtl/graph_segment_merger_top_macros.svh
// Assertion macros shared by the graph segment merger checker.
// No dependencies; include by bare file name.
`ifndef GRAPH_SEGMENT_MERGER_TOP_MACROS_SVH
`define GRAPH_SEGMENT_MERGER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("graph segment merger: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define GMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("graph segment merger: next-cycle check failed");

`endif

>>> rtl/gms_pkg.sv
// Package for the graph segment merger: item types, codes and constants.
// No dependencies.
package gms_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int NODE_W        = 10;
  localparam int COST_W        = 16;
  localparam int TAU_W         = 24;
  localparam int CNT_REG_W     = 11;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam logic [CNT_REG_W-1:0] NODE_COUNT_RST = 11'd1024;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_EDGE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } gms_op_t;

  // Register index taken from paddr bit 2
  localparam logic REG_NODE_COUNT    = 1'b0;
  localparam logic REG_CUT_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] edge_cost;
  } gms_in_t;

  typedef struct packed {
    logic              edge_kept;
    logic [NODE_W-1:0] segment_label;
    logic              input_error;
  } gms_out_t;

endpackage

>>> rtl/graph_segment_merger_top.sv
// Top level of the graph segment merger: sequencer, label and segment stores.
// Depends on gms_pkg and gms_div.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------------
//  command  | start, busy, cmd                        | taken when start && !busy
//  result   | result_valid, result                    | one-cycle strobe, no back-pressure
//  config   | psel, penable, pwrite, paddr, pwdata... | APB, pready always high
//
// Query: label read, then the result. Edge: answered straight from idle if flagged; kept inside
// a segment after the two label reads, or rejected after the segment reads and test; on a merge
// the relabel scan reads one label a cycle through the label memory read port (the divider
// runs alongside it). Start: a clearing sweep over all MAX_NODES entries, then the result.
// After reset the same sweep runs with busy high and no result.
// Results cannot be stalled; busy stays high until the result strobe.
module graph_segment_merger_top #(
  parameter int MAX_NODES = gms_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gms_pkg::ADDR_W-1:0]  paddr,
  input  logic [gms_pkg::DATA_W-1:0]  pwdata,
  output logic [gms_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  input  gms_pkg::gms_in_t            cmd,
  output logic                        busy,
  output logic                        result_valid,
  output gms_pkg::gms_out_t           result
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SZ_W  = IDX_W + 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int SEG_W = gms_pkg::COST_W + gms_pkg::TAU_W + SZ_W;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_QRD   = 12'b000000000100,
    S_QOUT  = 12'b000000001000,
    S_RDA   = 12'b000000010000,
    S_RDB   = 12'b000000100000,
    S_ORD   = 12'b000001000000,
    S_RDHI  = 12'b000010000000,
    S_CAP   = 12'b000100000000,
    S_TEST  = 12'b001000000000,
    S_SCAN  = 12'b010000000000,
    S_WAIT  = 12'b100000000000
  } gms_state_t;

  gms_state_t state;

  // Configuration registers
  logic [gms_pkg::CNT_REG_W-1:0] node_count;
  logic [gms_pkg::TAU_W-1:0]     cut_threshold;

  // Item registers
  logic [IDX_W-1:0]          a_q;
  logic [IDX_W-1:0]          b_q;
  logic [gms_pkg::COST_W-1:0] cost_q;
  logic [gms_pkg::COST_W-1:0] last_cost;
  logic [IDX_W-1:0]          lab1;
  logic [IDX_W-1:0]          lo_q;
  logic [IDX_W-1:0]          hi_q;
  logic [SEG_W-1:0]          lo_seg;
  logic [gms_pkg::COST_W-1:0] m_q;
  logic [SZ_W-1:0]           size_sum;
  logic [gms_pkg::TAU_W-1:0] clr_tau;
  logic                      clr_emit;
  logic [CNT_W-1:0]          cnt;
  logic                      pend;
  logic [IDX_W-1:0]          pend_addr;

  // Stores
  logic [IDX_W-1:0] label_mem [MAX_NODES];
  logic [SEG_W-1:0] seg_mem   [MAX_NODES];
  logic [IDX_W-1:0] label_q;
  logic [SEG_W-1:0] seg_q;

  logic             lwe;
  logic [IDX_W-1:0] lwaddr;
  logic [IDX_W-1:0] lwdata;
  logic [IDX_W-1:0] lraddr;
  logic             swe;
  logic [IDX_W-1:0] swaddr;
  logic [SEG_W-1:0] swdata;
  logic [IDX_W-1:0] sraddr;

  logic                      accept;
  logic                      a_oor;
  logic                      b_oor;
  logic [IDX_W-1:0]          lo_c;
  logic [IDX_W-1:0]          hi_c;
  logic [gms_pkg::COST_W-1:0] lo_max;
  logic [gms_pkg::COST_W-1:0] hi_max;
  logic [gms_pkg::TAU_W:0]   lim_lo;
  logic [gms_pkg::TAU_W:0]   lim_hi;
  logic [gms_pkg::TAU_W:0]   lim;
  logic [gms_pkg::COST_W-1:0] m_c;
  logic                      div_busy;
  logic [gms_pkg::TAU_W-1:0] div_q;
  logic                      div_start;
  logic                      cfg_we;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Range test against the effective node count
  assign a_oor = (gms_pkg::CNT_REG_W'(cmd.node_a) >= node_count) ||
                 (32'(cmd.node_a) >= 32'(MAX_NODES));
  assign b_oor = (gms_pkg::CNT_REG_W'(cmd.node_b) >= node_count) ||
                 (32'(cmd.node_b) >= 32'(MAX_NODES));

  // Order the two labels, smaller one survives
  assign lo_c = (label_q < lab1) ? label_q : lab1;
  assign hi_c = (label_q < lab1) ? lab1 : label_q;

  // Merge test on the two segment entries
  assign lo_max = lo_seg[SEG_W-1 -: gms_pkg::COST_W];
  assign hi_max = seg_q[SEG_W-1 -: gms_pkg::COST_W];
  assign lim_lo = (gms_pkg::TAU_W+1)'(lo_max) +
                  (gms_pkg::TAU_W+1)'(lo_seg[SZ_W+gms_pkg::TAU_W-1 -: gms_pkg::TAU_W]);
  assign lim_hi = (gms_pkg::TAU_W+1)'(hi_max) +
                  (gms_pkg::TAU_W+1)'(seg_q[SZ_W+gms_pkg::TAU_W-1 -: gms_pkg::TAU_W]);
  assign lim    = (lim_lo < lim_hi) ? lim_lo : lim_hi;

  always_comb begin
    m_c = cost_q;
    if (lo_max > m_c) begin
      m_c = lo_max;
    end
    if (hi_max > m_c) begin
      m_c = hi_max;
    end
  end

  assign div_start = (state == S_TEST) &&
                     ((gms_pkg::TAU_W+1)'(cost_q) <= lim);

  gms_div #(
    .DVW (SZ_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cut_threshold),
    .divisor  (SZ_W'(lo_seg[SZ_W-1:0] + seg_q[SZ_W-1:0])),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Steer the memory ports from the sequencer state
  always_comb begin
    lwe    = 1'b0;
    lwaddr = cnt[IDX_W-1:0];
    lwdata = cnt[IDX_W-1:0];
    lraddr = a_q;
    swe    = 1'b0;
    swaddr = cnt[IDX_W-1:0];
    swdata = {{gms_pkg::COST_W{1'b0}}, clr_tau, SZ_W'(1)};
    sraddr = lo_q;
    case (state)
      S_CLEAR: begin
        lwe = 1'b1;
        swe = 1'b1;
      end
      S_RDB:  lraddr = b_q;
      S_ORD:  sraddr = lo_c;
      S_RDHI: sraddr = hi_q;
      S_SCAN: begin
        lraddr = cnt[IDX_W-1:0];
        lwe    = pend && (label_q == hi_q);
        lwaddr = pend_addr;
        lwdata = lo_q;
      end
      S_WAIT: begin
        swe    = !div_busy;
        swaddr = lo_q;
        swdata = {m_q, div_q, size_sum};
      end
      default: begin
        lwe = 1'b0;
      end
    endcase
  end

  // Label store
  always_ff @(posedge clk) begin
    if (lwe) begin
      label_mem[lwaddr] <= lwdata;
    end
    label_q <= label_mem[lraddr];
  end

  // Segment store: max cost, tau, size
  always_ff @(posedge clk) begin
    if (swe) begin
      seg_mem[swaddr] <= swdata;
    end
    seg_q <= seg_mem[sraddr];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= gms_pkg::NODE_COUNT_RST;
      cut_threshold <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        gms_pkg::REG_NODE_COUNT:    node_count    <= pwdata[gms_pkg::CNT_REG_W-1:0];
        gms_pkg::REG_CUT_THRESHOLD: cut_threshold <= pwdata[gms_pkg::TAU_W-1:0];
        default:                    node_count    <= node_count;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[2])
      gms_pkg::REG_NODE_COUNT:    prdata = gms_pkg::DATA_W'(node_count);
      gms_pkg::REG_CUT_THRESHOLD: prdata = gms_pkg::DATA_W'(cut_threshold);
      default:                    prdata = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      clr_tau      <= '0;
      clr_emit     <= 1'b0;
      last_cost    <= '0;
      result_valid <= 1'b0;
      pend         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_q    <= IDX_W'(cmd.node_a);
            b_q    <= IDX_W'(cmd.node_b);
            cost_q <= cmd.edge_cost;
            case (cmd.operation)
              gms_pkg::OP_START: begin
                clr_tau   <= cut_threshold;
                clr_emit  <= 1'b1;
                cnt       <= '0;
                last_cost <= '0;
                state     <= S_CLEAR;
              end
              gms_pkg::OP_QUERY: begin
                if (a_oor) begin
                  result_valid <= 1'b1;
                  result       <= '{edge_kept: 1'b0, segment_label: '0, input_error: 1'b1};
                end else begin
                  state <= S_QRD;
                end
              end
              gms_pkg::OP_EDGE: begin
                if (a_oor || b_oor || (cmd.edge_cost < last_cost)) begin
                  result_valid <= 1'b1;
                  result       <= '{edge_kept: 1'b0, segment_label: '0, input_error: 1'b1};
                end else begin
                  last_cost <= cmd.edge_cost;
                  state     <= S_RDA;
                end
              end
              default: begin
                result_valid <= 1'b1;
                result       <= '0;
              end
            endcase
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(MAX_NODES - 1)) begin
            state <= S_IDLE;
            if (clr_emit) begin
              result_valid <= 1'b1;
              result       <= '0;
            end
          end
        end
        S_QRD: state <= S_QOUT;
        S_QOUT: begin
          result_valid <= 1'b1;
          result       <= '{edge_kept: 1'b0,
                            segment_label: gms_pkg::NODE_W'(label_q),
                            input_error: 1'b0};
          state        <= S_IDLE;
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          lab1  <= label_q;
          state <= S_ORD;
        end
        S_ORD: begin
          // Both ends already in one segment: keep the edge
          if (label_q == lab1) begin
            result_valid <= 1'b1;
            result       <= '{edge_kept: 1'b1,
                              segment_label: gms_pkg::NODE_W'(lab1),
                              input_error: 1'b0};
            state        <= S_IDLE;
          end else begin
            lo_q  <= lo_c;
            hi_q  <= hi_c;
            state <= S_RDHI;
          end
        end
        S_RDHI: state <= S_CAP;
        S_CAP: begin
          lo_seg <= seg_q;
          state  <= S_TEST;
        end
        S_TEST: begin
          if (div_start) begin
            m_q      <= m_c;
            size_sum <= SZ_W'(lo_seg[SZ_W-1:0] + seg_q[SZ_W-1:0]);
            cnt      <= '0;
            pend     <= 1'b0;
            state    <= S_SCAN;
          end else begin
            result_valid <= 1'b1;
            result       <= '0;
            state        <= S_IDLE;
          end
        end
        S_SCAN: begin
          // Read one label a cycle, rewrite the previous one if it names hi
          pend      <= (cnt < CNT_W'(MAX_NODES));
          pend_addr <= cnt[IDX_W-1:0];
          if (cnt == CNT_W'(MAX_NODES)) begin
            state <= S_WAIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_WAIT: begin
          if (!div_busy) begin
            result_valid <= 1'b1;
            result       <= '{edge_kept: 1'b1,
                              segment_label: gms_pkg::NODE_W'(lo_q),
                              input_error: 1'b0};
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/gms_div.sv
// Restoring divider, one quotient bit per cycle: cut threshold over segment size.
// Depends on gms_pkg.
module gms_div #(
  parameter int DVW = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [gms_pkg::TAU_W-1:0] dividend,
  input  logic [DVW-1:0]           divisor,
  output logic                     busy,
  output logic [gms_pkg::TAU_W-1:0] quotient
);

  localparam int STEP_W = $clog2(gms_pkg::TAU_W + 1);

  logic [DVW-1:0]            rem;
  logic [DVW-1:0]            dsr;
  logic [gms_pkg::TAU_W-1:0] quo;
  logic [STEP_W-1:0]         step;
  logic [DVW:0]              trial;
  logic                      fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[gms_pkg::TAU_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rem  <= '0;
      dsr  <= divisor;
      quo  <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DVW'(trial - {1'b0, dsr});
      end else begin
        rem <= DVW'(trial);
      end
      quo  <= {quo[gms_pkg::TAU_W-2:0], fits};
      step <= step + 1'b1;
      if (step == STEP_W'(gms_pkg::TAU_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/gms_checker.sv
// Port-level checks for the graph segment merger, bound to the top level.
// Depends on gms_pkg and graph_segment_merger_top_macros.svh.
`include "graph_segment_merger_top_macros.svh"

module gms_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input gms_pkg::gms_out_t result
);

  // An accepted item either occupies the block or answers at once
  `GMS_ASSERT_NEXT(a_accept_acts, start && !busy, busy || result_valid)
  // The result strobe ends the busy period
  `GMS_ASSERT_NOW(a_result_idle, result_valid, !busy)
  // No result without work in flight
  `GMS_ASSERT_NEXT(a_no_spurious, !busy && !start, !result_valid)
  // A flagged item carries no kept edge and no label
  `GMS_ASSERT_NOW(a_error_clean, result_valid && result.input_error,
                  !result.edge_kept && (result.segment_label == '0))

endmodule

bind graph_segment_merger_top gms_checker u_gms_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
